@@ hdl/aae_pkg.sv @@
// shared types and constants of the adaptive arithmetic encoder
package aae_pkg;

    localparam int CODE_BITS_DEF  = 17;
    localparam int MAX_TOTAL_DEF  = 32768;
    localparam int ALPHABET_DEF   = 256;
    localparam int FOLLOW_CAP_DEF = 448;

    localparam int SYM_W      = 9;
    localparam int CNT_W      = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;
    localparam int MAX_EMIT   = 64;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_HI,
        ST_RD_LO,
        ST_DIV,
        ST_NEWIV,
        ST_REN,
        ST_FOLLOW,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_FIN_DEFER,
        ST_FIN_BIT,
        ST_FLUSH
    } state_t;

endpackage

@@ hdl/adaptive_arithmetic_encoder.sv @@
// adaptive arithmetic encoder top level with frequency table memory
//
// channel   dir  transfer content
// s_*       in   tdata[8:0] symbol (0..255 data, 256 end of message)
// m_*       out  tdata[7:0] out_byte, tlast last, tuser follow_overflow
//
// one symbol at a time: two table reads, two multiplies with a 1-bit-per-cycle
// divider, the renormalization steps and each pending bit sent, then the model
// update, which walks up to 258 table entries
// after reset and after every end of message all 258 table entries are rewritten
// a stalled output holds every step that puts a code bit
module adaptive_arithmetic_encoder #(
    parameter int CODE_BITS  = aae_pkg::CODE_BITS_DEF,
    parameter int MAX_TOTAL  = aae_pkg::MAX_TOTAL_DEF,
    parameter int ALPHABET   = aae_pkg::ALPHABET_DEF,
    parameter int FOLLOW_CAP = aae_pkg::FOLLOW_CAP_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [aae_pkg::IN_DATA_W-1:0]    s_tdata,   // symbol
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [aae_pkg::OUT_DATA_W-1:0]   m_tdata,   // out_byte
    output logic                             m_tlast,
    output logic                             m_tuser    // follow_overflow
);
    import aae_pkg::*;

    localparam int NSYM  = ALPHABET + 1;
    localparam int DEPTH = ALPHABET + 2;
    localparam int IW    = $clog2(DEPTH);
    localparam int PW    = $clog2(FOLLOW_CAP + 1);
    localparam int DW    = CODE_BITS + 1 + CNT_W;
    localparam int CW    = $clog2(DW);
    localparam int EW    = $clog2(MAX_EMIT + 1);
    localparam logic [CODE_BITS-1:0] TOP   = {CODE_BITS{1'b1}};
    localparam logic [CODE_BITS-1:0] FQ    = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] HALF  = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] TQ    = HALF + FQ;
    localparam logic [IW-1:0]        NSYM_I = IW'(NSYM);

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] mem_rdata;
    logic [IW-1:0]    mem_addr;
    logic             mem_we;
    logic [CNT_W-1:0] mem_wdata;

    state_t state_reg, state_next;
    logic [CODE_BITS-1:0] low_reg, low_next, high_reg, high_next;
    logic [PW-1:0]        pend_reg, pend_next;
    logic [7:0]           buf_reg, buf_next;
    logic [3:0]           free_reg, free_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_W-1:0]     tot_reg, tot_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]     hi_cnt_reg, hi_cnt_next, lo_cnt_reg, lo_cnt_next;
    logic [DW-1:0]        a_reg, a_next, quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]        dcnt_reg, dcnt_next;
    logic                 phase_reg, phase_next;
    logic                 fbit_reg, fbit_next;
    logic                 ret_flush_reg, ret_flush_next;
    logic [EW-1:0]        emit_cnt_reg, emit_cnt_next;
    logic [CNT_W-1:0]     cur_reg, cur_next, acc_reg, acc_next;
    logic                 halve_reg, halve_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next, out_ovf_reg, out_ovf_next;

    logic                 out_free;
    logic [CODE_BITS:0]   range;
    logic [CNT_W-1:0]     tot_eff;
    logic [CNT_W:0]       div_t;
    logic                 div_ge;
    logic [DW-1:0]        div_q;
    logic [DW:0]          nlo, nhi;
    logic                 pb_do, pb_bit;
    logic                 emit_do, emit_last;
    logic [7:0]           emit_byte;
    logic [7:0]           pb_buf;
    logic [3:0]           pb_free;
    logic [CNT_W-1:0]     half_f;
    logic [CNT_W-1:0]     upd_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign range    = {1'b0, high_reg} - {1'b0, low_reg} + (CODE_BITS+1)'(1);
    assign tot_eff  = (tot_reg == '0) ? CNT_W'(1) : tot_reg;
    assign div_t    = {rem_reg, quo_reg[DW-1]};
    assign div_ge   = div_t >= {1'b0, tot_eff};
    assign div_q    = {quo_reg[DW-2:0], div_ge};
    assign nlo      = {1'b0, DW'(low_reg)} + {1'b0, quo_reg};
    assign nhi      = {1'b0, DW'(low_reg)} + {1'b0, a_reg};
    assign half_f   = CNT_W'(((CNT_W+1)'(mem_rdata) - (CNT_W+1)'(cur_reg)
                              + (CNT_W+1)'(1)) >> 1);
    assign upd_inc  = (idx_reg > IW'(sym_reg)) ? CNT_W'(1) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        pend_next      = pend_reg;
        ovf_next       = ovf_reg;
        tot_next       = tot_reg;
        sym_next       = sym_reg;
        idx_next       = idx_reg;
        hi_cnt_next    = hi_cnt_reg;
        lo_cnt_next    = lo_cnt_reg;
        a_next         = a_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        phase_next     = phase_reg;
        fbit_next      = fbit_reg;
        ret_flush_next = ret_flush_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        halve_next     = halve_reg;
        mem_addr       = idx_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        pb_do          = 1'b0;
        pb_bit         = 1'b0;
        emit_do        = 1'b0;
        emit_last      = 1'b0;
        emit_byte      = '0;
        buf_next       = buf_reg;
        free_next      = free_reg;
        pb_buf         = '0;
        pb_free        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = CNT_W'(idx_reg);
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == NSYM_I)
                begin
                    tot_next   = CNT_W'(NSYM);
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                mem_addr = IW'(s_tdata[SYM_W-1:0]) + IW'(1);
                if (s_tvalid && (s_tdata[SYM_W-1:0] <= SYM_W'(ALPHABET)))
                begin
                    sym_next   = s_tdata[SYM_W-1:0];
                    state_next = ST_RD_HI;
                end
            end
            ST_RD_HI:
            begin
                mem_addr    = IW'(sym_reg);
                hi_cnt_next = mem_rdata;
                state_next  = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                lo_cnt_next = mem_rdata;
                quo_next    = DW'(range) * DW'(hi_cnt_reg);
                rem_next    = '0;
                dcnt_next   = '0;
                phase_next  = 1'b0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next  = div_q;
                rem_next  = div_ge ? CNT_W'(div_t - {1'b0, tot_eff}) : div_t[CNT_W-1:0];
                dcnt_next = dcnt_reg + CW'(1);
                if (dcnt_reg == CW'(DW - 1))
                begin
                    if (!phase_reg)
                    begin
                        a_next     = div_q;
                        quo_next   = DW'(range) * DW'(lo_cnt_reg);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_NEWIV;
                    end
                end
            end
            ST_NEWIV:
            begin
                low_next   = nlo[CODE_BITS-1:0];
                high_next  = (nhi > nlo) ? CODE_BITS'(nhi - (DW+1)'(1)) : nhi[CODE_BITS-1:0];
                state_next = ST_REN;
            end
            ST_REN:
            begin
                if (high_reg < HALF || low_reg >= HALF)
                begin
                    if (out_free)
                    begin
                        pb_do          = 1'b1;
                        pb_bit         = (low_reg >= HALF);
                        fbit_next      = pb_bit;
                        ret_flush_next = 1'b0;
                        if (pb_bit)
                        begin
                            low_next  = ((low_reg - HALF) << 1) & TOP;
                            high_next = ((high_reg - HALF) << 1) | CODE_BITS'(1);
                        end
                        else
                        begin
                            low_next  = (low_reg << 1) & TOP;
                            high_next = (high_reg << 1) | CODE_BITS'(1);
                        end
                        if (pend_reg != '0)
                        begin
                            state_next = ST_FOLLOW;
                        end
                    end
                end
                else if (low_reg >= FQ && high_reg < TQ)
                begin
                    if (pend_reg < PW'(FOLLOW_CAP))
                    begin
                        pend_next = pend_reg + PW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    low_next  = ((low_reg - FQ) << 1) & TOP;
                    high_next = ((high_reg - FQ) << 1) | CODE_BITS'(1);
                end
                else if (sym_reg < SYM_W'(ALPHABET))
                begin
                    halve_next = (tot_reg >= CNT_W'(MAX_TOTAL));
                    cur_next   = '0;
                    acc_next   = '0;
                    idx_next   = (tot_reg >= CNT_W'(MAX_TOTAL)) ? '0 : IW'(sym_reg) + IW'(1);
                    state_next = ST_UPD_RD;
                end
                else
                begin
                    state_next = ST_FIN_DEFER;
                end
            end
            ST_FOLLOW:
            begin
                if (out_free)
                begin
                    pb_do     = 1'b1;
                    pb_bit    = !fbit_reg;
                    pend_next = pend_reg - PW'(1);
                    if (pend_reg == PW'(1))
                    begin
                        state_next = ret_flush_reg ? ST_FLUSH : ST_REN;
                    end
                end
            end
            ST_UPD_RD:
            begin
                mem_addr   = (halve_reg && idx_reg != NSYM_I) ? idx_reg + IW'(1) : idx_reg;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                mem_we = 1'b1;
                if (halve_reg)
                begin
                    mem_wdata = acc_reg + upd_inc;
                    acc_next  = acc_reg + half_f;
                    cur_next  = mem_rdata;
                end
                else
                begin
                    mem_wdata = mem_rdata + CNT_W'(1);
                end
                idx_next   = idx_reg + IW'(1);
                state_next = ST_UPD_RD;
                if (idx_reg == NSYM_I)
                begin
                    tot_next   = mem_wdata;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_DEFER:
            begin
                if (pend_reg < PW'(FOLLOW_CAP))
                begin
                    pend_next = pend_reg + PW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = ST_FIN_BIT;
            end
            ST_FIN_BIT:
            begin
                if (out_free)
                begin
                    pb_do          = 1'b1;
                    pb_bit         = (low_reg >= FQ);
                    fbit_next      = pb_bit;
                    ret_flush_next = 1'b1;
                    state_next     = ST_FOLLOW;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit_do    = 1'b1;
                    emit_last  = 1'b1;
                    emit_byte  = (free_reg >= 4'd8) ? 8'd0 : 8'(buf_reg >> free_reg);
                    low_next   = '0;
                    high_next  = TOP;
                    pend_next  = '0;
                    buf_next   = '0;
                    free_next  = 4'd8;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase

        if (pb_do)
        begin
            pb_buf  = {pb_bit, buf_reg[7:1]};
            pb_free = free_reg - 4'd1;
            buf_next = pb_buf;
            if (pb_free == 4'd0)
            begin
                emit_do   = 1'b1;
                emit_byte = pb_buf;
                free_next = 4'd8;
            end
            else
            begin
                free_next = pb_free;
            end
        end

        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        emit_cnt_next  = (state_reg == ST_IDLE) ? '0 : emit_cnt_reg;
        if (emit_do && emit_cnt_reg < EW'(MAX_EMIT))
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
            out_ovf_next   = ovf_reg;
            emit_cnt_next  = emit_cnt_reg + EW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            low_reg       <= '0;
            high_reg      <= TOP;
            pend_reg      <= '0;
            buf_reg       <= '0;
            free_reg      <= 4'd8;
            ovf_reg       <= 1'b0;
            tot_reg       <= CNT_W'(NSYM);
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            pend_reg      <= pend_next;
            buf_reg       <= buf_next;
            free_reg      <= free_next;
            ovf_reg       <= ovf_next;
            tot_reg       <= tot_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        hi_cnt_reg    <= hi_cnt_next;
        lo_cnt_reg    <= lo_cnt_next;
        a_reg         <= a_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dcnt_reg      <= dcnt_next;
        phase_reg     <= phase_next;
        fbit_reg      <= fbit_next;
        ret_flush_reg <= ret_flush_next;
        cur_reg       <= cur_next;
        acc_reg       <= acc_next;
        halve_reg     <= halve_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[SYM_W-1:0] <= SYM_W'(ALPHABET)) |=> !s_tready)
        else $error("encoder took a symbol while busy");

    a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PW'(FOLLOW_CAP))
        else $error("pending bit count above cap");

    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (high_reg >= low_reg))
        else $error("interval inverted between symbols");

endmodule

@@ tb/tb_adaptive_arithmetic_encoder.sv @@
// self-checking testbench of the adaptive arithmetic encoder with a built-in coder model
module tb_adaptive_arithmetic_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TOP_VAL   = 64'd131071;
    localparam longint unsigned QTR1_VAL  = 64'd32768;
    localparam longint unsigned HALF_VAL  = 64'd65536;
    localparam longint unsigned QTR3_VAL  = 64'd98304;
    localparam int unsigned     EOM_SYM   = aae_pkg::ALPHABET_DEF;
    localparam int unsigned     NSYM      = aae_pkg::ALPHABET_DEF + 1;
    localparam int              IDLE_LIMIT = 40000;

    typedef struct {
        logic [8:0] sym;
        bit         drain;
    } sym_item_t;

    typedef struct {
        logic [7:0] code;
        bit         last;
        bit         ovf;
    } code_byte_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [aae_pkg::IN_DATA_W-1:0]     s_tdata;   // symbol
    logic                              m_tvalid;
    logic                              m_tready;
    logic [aae_pkg::OUT_DATA_W-1:0]    m_tdata;   // out_byte
    logic                              m_tlast;
    logic                              m_tuser;   // follow_overflow

    adaptive_arithmetic_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sym_item_t  sym_q[$];
    code_byte_t code_q[$];
    int         errors;
    int         sent;
    int         total_items;
    int         received;
    int         idle_cycles;
    int         hold_cnt;
    int         phase;

    longint unsigned iv_lo;
    longint unsigned iv_hi;
    int unsigned     pend;
    logic [7:0]      bbuf;
    int unsigned     free_n;
    int unsigned     cum [0:257];
    bit              ovf_seen;
    int              emit_n;

    task automatic reset_coder();
        iv_lo    = 0;
        iv_hi    = TOP_VAL;
        pend     = 0;
        bbuf     = 8'd0;
        free_n   = 8;
        ovf_seen = 1'b0;
        for (int i = 0; i <= NSYM; i++)
            cum[i] = i;
    endtask

    task automatic emit_code(logic [7:0] b, bit l);
        code_byte_t e;
        if (emit_n < aae_pkg::MAX_EMIT)
        begin
            e.code = b;
            e.last = l;
            e.ovf  = ovf_seen;
            code_q = {code_q, e};
            emit_n++;
        end
    endtask

    task automatic shift_bit(bit b);
        bbuf = {b, bbuf[7:1]};
        if (free_n > 0)
            free_n--;
        if (free_n == 0)
        begin
            emit_code(bbuf, 1'b0);
            free_n = 8;
        end
    endtask

    task automatic shift_with_pending(bit b);
        shift_bit(b);
        while (pend > 0)
        begin
            shift_bit(~b);
            pend--;
        end
    endtask

    task automatic defer_one();
        if (pend < aae_pkg::FOLLOW_CAP_DEF)
            pend++;
        else
            ovf_seen = 1'b1;
    endtask

    task automatic narrow_interval(int unsigned s);
        longint unsigned rng, tot, a, b, nlo, nhi;
        rng = iv_hi - iv_lo + 1;
        tot = cum[NSYM];
        if (tot == 0)
            tot = 1;
        a = rng * cum[s + 1] / tot;
        b = rng * cum[s] / tot;
        nlo = iv_lo + b;
        nhi = iv_lo + a;
        if (nhi > nlo)
            nhi = nhi - 1;
        iv_lo = nlo & TOP_VAL;
        iv_hi = nhi & TOP_VAL;
        forever
        begin
            if (iv_hi < HALF_VAL)
                shift_with_pending(1'b0);
            else if (iv_lo >= HALF_VAL)
            begin
                shift_with_pending(1'b1);
                iv_lo -= HALF_VAL;
                iv_hi -= HALF_VAL;
            end
            else if (iv_lo >= QTR1_VAL && iv_hi < QTR3_VAL)
            begin
                defer_one();
                iv_lo -= QTR1_VAL;
                iv_hi -= QTR1_VAL;
            end
            else
                break;
            iv_lo = (iv_lo << 1) & TOP_VAL;
            iv_hi = ((iv_hi << 1) | 1) & TOP_VAL;
        end
    endtask

    task automatic bump_counts(int unsigned s);
        int unsigned acc, f;
        if (cum[NSYM] >= aae_pkg::MAX_TOTAL_DEF)
        begin
            acc = 0;
            for (int i = 0; i < NSYM; i++)
            begin
                f = (cum[i + 1] - cum[i] + 1) >> 1;
                cum[i] = acc;
                acc += f;
            end
            cum[NSYM] = acc;
        end
        for (int i = s + 1; i <= NSYM; i++)
            cum[i] = (cum[i] + 1) & 32'hffff;
    endtask

    task automatic predict_symbol(logic [8:0] sym);
        int unsigned s;
        s = sym;
        if (s > EOM_SYM)
            return;
        emit_n = 0;
        narrow_interval(s);
        if (s < EOM_SYM)
            bump_counts(s);
        else
        begin
            defer_one();
            shift_with_pending(iv_lo < QTR1_VAL ? 1'b0 : 1'b1);
            emit_code(free_n >= 8 ? 8'd0 : (bbuf >> free_n), 1'b1);
            reset_coder();
        end
    endtask

    task automatic add_sym(int s, bit drain);
        sym_item_t it;
        it.sym   = s[8:0];
        it.drain = drain;
        sym_q = {sym_q, it};
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit        offer;
        sym_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_symbol(s_tdata[8:0]);
                sent++;
                phase = sent * 3 / total_items;
                offer = 1'b0;
            end
            if (!offer && sym_q.size() > 0)
            begin
                nxt = sym_q[0];
                if (nxt.drain && code_q.size() != 0)
                    offer = 1'b0;
                else if (phase == 0)
                    offer = $urandom_range(99) >= 7;
                else if (phase == 1)
                    offer = $urandom_range(99) >= 60;
                else
                    offer = 1'b1;
                if (offer)
                begin
                    void'(sym_q.pop_front());
                    s_tdata <= {7'd0, nxt.sym};
                end
            end
            s_tvalid <= offer;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        code_byte_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("adaptive_arithmetic_encoder verification failed");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                received++;
                if (received == 40)
                    hold_cnt = 3000;
                if (code_q.size() == 0)
                begin
                    $error("unexpected transfer out_byte=%0h", m_tdata);
                    errors++;
                end
                else
                begin
                    e = code_q.pop_front();
                    if (m_tdata !== e.code)
                    begin
                        $error("out_byte expected %0h actual %0h", e.code, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last expected %0d actual %0d", e.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== e.ovf)
                    begin
                        $error("follow_overflow expected %0d actual %0d", e.ovf, m_tuser);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (phase == 0)
                m_tready <= $urandom_range(99) >= 60;
            else if (phase == 1)
                m_tready <= $urandom_range(99) >= 7;
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int len;
        errors      = 0;
        sent        = 0;
        received    = 0;
        idle_cycles = 0;
        hold_cnt    = 0;
        phase       = 0;
        reset_coder();
        rst_n = 1'b0;

        // directed: extremes, empty message, ignored codes
        add_sym(EOM_SYM, 1'b0);
        add_sym(0, 1'b0);
        add_sym(255, 1'b0);
        add_sym(EOM_SYM, 1'b0);
        add_sym(257, 1'b0);
        add_sym(511, 1'b0);
        add_sym(9'h155, 1'b0);
        add_sym(9'h0aa, 1'b0);
        add_sym(9'h055, 1'b0);
        add_sym(EOM_SYM, 1'b0);
        for (int i = 0; i < 8; i++)
            add_sym(255, 1'b0);
        add_sym(EOM_SYM, 1'b0);
        for (int i = 0; i < 5; i++)
            add_sym(0, 1'b0);
        add_sym(EOM_SYM, 1'b1);

        // random messages with some noise
        while (sym_q.size() < 330)
        begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 8)
                    add_sym($urandom_range(511, 257), 1'b0);
                else if ($urandom_range(99) < 30)
                    add_sym($urandom_range(3) + 'h40, 1'b0);
                else
                    add_sym($urandom_range(255), 1'b0);
            end
            add_sym(EOM_SYM, $urandom_range(99) < 10);
        end
        total_items = sym_q.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (sym_q.size() == 0 && !s_tvalid);
        wait (code_q.size() == 0);
        repeat (2000) @(posedge clk);
        if (errors == 0 && code_q.size() == 0)
            $display("adaptive_arithmetic_encoder verification clean");
        else
        begin
            if (code_q.size() != 0)
                $error("%0d expected transfers never arrived", code_q.size());
            $display("adaptive_arithmetic_encoder verification failed");
        end
        $finish;
    end
endmodule
